### hdl/arp_pkg.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher package
// Relocation type codes, the internal operation classes, status codes and
// the decoder that maps a type code onto its operation class.
// ----------------------------------------------------------------------------
package arp_pkg;

	localparam int unsigned KIND_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned STAT_W = 2;

	localparam logic [KIND_W-1:0] KIND_NONE        = 8'd0;
	localparam logic [KIND_W-1:0] KIND_ABS32       = 8'd2;
	localparam logic [KIND_W-1:0] KIND_REL32       = 8'd3;
	localparam logic [KIND_W-1:0] KIND_THM_CALL    = 8'd10;
	localparam logic [KIND_W-1:0] KIND_CALL        = 8'd28;
	localparam logic [KIND_W-1:0] KIND_JUMP24      = 8'd29;
	localparam logic [KIND_W-1:0] KIND_TARGET1     = 8'd38;
	localparam logic [KIND_W-1:0] KIND_V4BX        = 8'd40;
	localparam logic [KIND_W-1:0] KIND_TARGET2     = 8'd41;
	localparam logic [KIND_W-1:0] KIND_PREL31      = 8'd42;
	localparam logic [KIND_W-1:0] KIND_MOVW_ABS    = 8'd43;
	localparam logic [KIND_W-1:0] KIND_MOVT_ABS    = 8'd44;
	localparam logic [KIND_W-1:0] KIND_THM_MOVW    = 8'd47;
	localparam logic [KIND_W-1:0] KIND_THM_MOVT    = 8'd48;

	typedef enum logic [STAT_W-1:0] {
		ST_PATCHED = 2'd0,
		ST_NOOP    = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_NOOP,
		OP_UNKNOWN,
		OP_ABS,
		OP_REL,
		OP_PREL31,
		OP_BRANCH,
		OP_THM_CALL,
		OP_MOVW,
		OP_MOVT,
		OP_THM_MOVW,
		OP_THM_MOVT
	} op_t;

	function automatic op_t decode_kind(input logic [KIND_W-1:0] kind);
		op_t op;
		unique case (kind)
			KIND_NONE, KIND_V4BX:       op = OP_NOOP;
			KIND_ABS32, KIND_TARGET1:   op = OP_ABS;
			KIND_REL32, KIND_TARGET2:   op = OP_REL;
			KIND_PREL31:                op = OP_PREL31;
			KIND_CALL, KIND_JUMP24:     op = OP_BRANCH;
			KIND_THM_CALL:              op = OP_THM_CALL;
			KIND_MOVW_ABS:              op = OP_MOVW;
			KIND_MOVT_ABS:              op = OP_MOVT;
			KIND_THM_MOVW:              op = OP_THM_MOVW;
			KIND_THM_MOVT:              op = OP_THM_MOVT;
			default:                    op = OP_UNKNOWN;
		endcase
		return op;
	endfunction

endpackage

### hdl/arp_if.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher channels
// Valid/ready channels for relocation requests and patched-word responses.
// ----------------------------------------------------------------------------
interface arp_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  kind;
	logic [31:0] symbol_addr;
	logic [31:0] addend;
	logic [31:0] place_addr;
	logic [31:0] old_word;

	modport source (
		output valid, kind, symbol_addr, addend, place_addr, old_word,
		input  ready
	);
	modport sink (
		input  valid, kind, symbol_addr, addend, place_addr, old_word,
		output ready
	);
endinterface

interface arp_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_word;
	logic [1:0]  status;

	modport source (
		output valid, new_word, status,
		input  ready
	);
	modport sink (
		input  valid, new_word, status,
		output ready
	);
endinterface

### hdl/arp_patch.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher field insertion
// Builds the patched word from the old word, S+A and S+A-P for one
// operation class, and gives the status code of that class.
// ----------------------------------------------------------------------------
module arp_patch (
	input  arp_pkg::op_t    op,
	input  logic [31:0]     old_word,
	input  logic [31:0]     sa,
	input  logic [31:0]     rel,
	output logic [31:0]     new_word,
	output arp_pkg::status_t status
);
	import arp_pkg::*;

	logic [15:0] half;
	logic        sg;

	assign half = (op == OP_MOVT || op == OP_THM_MOVT) ? sa[31:16] : sa[15:0];
	assign sg   = rel[24];

	always_comb begin
		unique case (op)
			OP_ABS:      new_word = sa;
			OP_REL:      new_word = rel;
			OP_PREL31:   new_word = {old_word[31], rel[30:0]};
			OP_BRANCH:   new_word = {old_word[31:24], rel[25:2]};
			OP_THM_CALL: new_word = {old_word[31:30], sg ^ ~rel[23], old_word[28],
				sg ^ ~rel[22], rel[11:1], old_word[15:11], sg, rel[21:12]};
			OP_MOVW, OP_MOVT: new_word = {old_word[31:20], half[15:12],
				old_word[15:12], half[11:0]};
			OP_THM_MOVW, OP_THM_MOVT: new_word = {old_word[31], half[10:8],
				old_word[27:24], half[7:0], old_word[15:11], half[11],
				old_word[9:4], half[15:12]};
			default:     new_word = old_word;
		endcase
	end

	always_comb begin
		unique case (op)
			OP_NOOP:    status = ST_NOOP;
			OP_UNKNOWN: status = ST_UNKNOWN;
			default:    status = ST_PATCHED;
		endcase
	end

endmodule

### hdl/arm_relocation_patcher.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher
// Applies one ELF relocation to a 32-bit word: decode and S+A, then S+A-P,
// then field insertion into a registered output.
// ----------------------------------------------------------------------------
// Pipeline: three register stages; a response is valid once its request item
// has been accepted and has passed through stages s1, s2 and s3 in order.
// Throughput: one item per cycle while rsp.ready is high; a stall at the response
// side holds every full stage in place, while empty stages keep filling.
// Reset: arst_n clears all stage valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module arm_relocation_patcher (
	input  logic           clk,
	input  logic           arst_n,
	arp_req_if.sink        req,
	arp_rsp_if.source      rsp
);
	import arp_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        en_s1, en_s2, en_s3;
	op_t         op_s1, op_s2;
	logic [31:0] sa_s1, sa_s2;
	logic [31:0] p_s1;
	logic [31:0] w_s1, w_s2;
	logic [31:0] rel_s2;
	logic [31:0] word_s3;
	status_t     status_s3;
	logic [31:0] patched;
	status_t     patch_status;

	assign en_s3 = !v_s3 || rsp.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			op_s1 <= decode_kind(req.kind);
			sa_s1 <= req.symbol_addr + req.addend;
			p_s1  <= req.place_addr;
			w_s1  <= req.old_word;
		end
		if (en_s2 && v_s1) begin
			op_s2  <= op_s1;
			sa_s2  <= sa_s1;
			rel_s2 <= sa_s1 - p_s1;
			w_s2   <= w_s1;
		end
		if (en_s3 && v_s2) begin
			word_s3   <= patched;
			status_s3 <= patch_status;
		end
	end

	arp_patch u_patch (
		.op       (op_s2),
		.old_word (w_s2),
		.sa       (sa_s2),
		.rel      (rel_s2),
		.new_word (patched),
		.status   (patch_status)
	);

	assign rsp.valid    = v_s3;
	assign rsp.new_word = word_s3;
	assign rsp.status   = status_s3;

endmodule
